### rtl/vgm_command_stream_converter_assert.svh
// Assertion macros shared by the command stream converter modules.
// Both macros use the clk and rst_n of the module in which they are used.
`ifndef VGM_COMMAND_STREAM_CONVERTER_ASSERT_SVH
`define VGM_COMMAND_STREAM_CONVERTER_ASSERT_SVH
`ifndef SYNTHESIS
`define VGM_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vgm_csc assertion failed");
`define VGM_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vgm_csc assertion failed");
`else
`define VGM_ASSERT_SAME(name, ante, cons)
`define VGM_ASSERT_NEXT(name, ante, cons)
`endif
`endif

### rtl/vgm_csc_pkg.sv
// Types and constants of the command stream converter.
// No dependencies; used by the controller, datapath and top level.
package vgm_csc_pkg;

    localparam logic [7:0] OPC_WRITE    = 8'h54;
    localparam logic [7:0] OPC_WAIT     = 8'h61;
    localparam logic [7:0] OPC_WAIT735  = 8'h62;
    localparam logic [7:0] OPC_END      = 8'h66;
    localparam logic [7:0] OPC_SHORT_LO = 8'h70;
    localparam logic [7:0] OPC_SHORT_HI = 8'h7F;

    localparam logic [7:0] WAIT735_LO = 8'hDF;
    localparam logic [7:0] WAIT735_HI = 8'h02;

    localparam logic [15:0] PIECE_MAX  = 16'h07FF;
    localparam logic [7:0]  PIECE_HI   = 8'h07;
    localparam logic [7:0]  PIECE_LO   = 8'hFF;

    localparam logic [7:0] ADDR_MASK_A = 8'h14;
    localparam logic [7:0] MASK_A      = 8'hF3;
    localparam logic [7:0] ADDR_MASK_B = 8'h1B;
    localparam logic [7:0] MASK_B      = 8'h3F;

    localparam logic [2:0] KIND_WRITE = 3'd0;
    localparam logic [2:0] KIND_SHORT = 3'd1;
    localparam logic [2:0] KIND_LONG  = 3'd2;
    localparam logic [2:0] KIND_END   = 3'd3;
    localparam logic [2:0] KIND_BAD   = 3'd4;

    typedef enum logic [2:0] {
        OPCL_SHORT,
        OPCL_WRITE,
        OPCL_WAIT,
        OPCL_WAIT735,
        OPCL_END,
        OPCL_BAD
    } op_class_t;

    typedef enum logic [2:0] {
        OUT_NONE,
        OUT_SHORT,
        OUT_WRITE,
        OUT_PIECE,
        OUT_END,
        OUT_BAD
    } out_op_t;

    typedef struct packed {
        logic    hold_addr;
        logic    hold_low;
        logic    load_wait;
        logic    load_wait735;
        out_op_t out_op;
    } dp_cmd_t;

    typedef struct packed {
        op_class_t op_class;
        logic      out_free;
        logic      len_big;
    } dp_status_t;

endpackage

### rtl/vgm_csc_if.sv
// Valid/ready channel interfaces: stream bytes in, playback records out.
// Depends on nothing; neither interface has a clock or reset port.
interface vgm_csc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink (input valid, input stream_byte, output ready);
endinterface

interface vgm_csc_rec_if;
    logic       valid;
    logic       ready;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [2:0] record_kind;
    logic       last_of_run;

    modport source (output valid, output first_byte, output second_byte,
                    output record_kind, output last_of_run, input ready);
    modport sink (input valid, input first_byte, input second_byte,
                  input record_kind, input last_of_run, output ready);
endinterface

### rtl/vgm_command_stream_converter.sv
// Command stream converter: one stream byte per transaction in, two-byte records out.
// A record appears in the output register in the cycle after the byte that ends it;
// the first piece of a long wait is registered from the loaded wait counter in ST_LONG.
// Throughput: 1 byte per cycle while the output is taken; a long wait holds the input
// in ST_LONG while the piece counter emits one record per cycle whenever the output is free.
// Reset: rst_n (async, active low) returns the parser to the opcode phase, empties
// the output register and clears the held address, wait byte and wait counter.
module vgm_command_stream_converter (
    input  logic               clk,
    input  logic               rst_n,
    vgm_csc_byte_if.sink       in_stream,
    vgm_csc_rec_if.source      out_record
);

    vgm_csc_pkg::dp_cmd_t    cmd;
    vgm_csc_pkg::dp_status_t status;

    vgm_csc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_stream.valid),
        .in_ready (in_stream.ready),
        .status   (status),
        .cmd      (cmd)
    );

    vgm_csc_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .stream_byte (in_stream.stream_byte),
        .cmd         (cmd),
        .status      (status),
        .out_ready   (out_record.ready),
        .out_valid   (out_record.valid),
        .first_byte  (out_record.first_byte),
        .second_byte (out_record.second_byte),
        .record_kind (out_record.record_kind),
        .last_of_run (out_record.last_of_run)
    );

endmodule

### rtl/vgm_csc_dp.sv
// Datapath: opcode decode, held operands, long wait counter, output register.
// Depends on vgm_csc_pkg and the assertion macro header.
`include "vgm_command_stream_converter_assert.svh"

module vgm_csc_dp (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [7:0]              stream_byte,
    input  vgm_csc_pkg::dp_cmd_t    cmd,
    output vgm_csc_pkg::dp_status_t status,
    input  logic                    out_ready,
    output logic                    out_valid,
    output logic [7:0]              first_byte,
    output logic [7:0]              second_byte,
    output logic [2:0]              record_kind,
    output logic                    last_of_run
);

    logic [7:0]  addr_reg, addr_next;
    logic [7:0]  low_reg, low_next;
    logic [15:0] len_reg, len_next;
    logic        valid_reg, valid_next;
    logic [7:0]  first_reg, first_next;
    logic [7:0]  second_reg, second_next;
    logic [2:0]  kind_reg, kind_next;
    logic        last_reg, last_next;
    logic [7:0]  masked_data;
    logic        len_big;
    logic        out_free;

    assign len_big  = len_reg > vgm_csc_pkg::PIECE_MAX;
    assign out_free = !valid_reg || out_ready;

    always_comb
    begin
        if (stream_byte inside {[vgm_csc_pkg::OPC_SHORT_LO : vgm_csc_pkg::OPC_SHORT_HI]})
        begin
            status.op_class = vgm_csc_pkg::OPCL_SHORT;
        end
        else if (stream_byte == vgm_csc_pkg::OPC_WRITE)
        begin
            status.op_class = vgm_csc_pkg::OPCL_WRITE;
        end
        else if (stream_byte == vgm_csc_pkg::OPC_WAIT)
        begin
            status.op_class = vgm_csc_pkg::OPCL_WAIT;
        end
        else if (stream_byte == vgm_csc_pkg::OPC_WAIT735)
        begin
            status.op_class = vgm_csc_pkg::OPCL_WAIT735;
        end
        else if (stream_byte == vgm_csc_pkg::OPC_END)
        begin
            status.op_class = vgm_csc_pkg::OPCL_END;
        end
        else
        begin
            status.op_class = vgm_csc_pkg::OPCL_BAD;
        end
        status.out_free = out_free;
        status.len_big  = len_big;
    end

    always_comb
    begin
        if (addr_reg == vgm_csc_pkg::ADDR_MASK_A)
        begin
            masked_data = stream_byte & vgm_csc_pkg::MASK_A;
        end
        else if (addr_reg == vgm_csc_pkg::ADDR_MASK_B)
        begin
            masked_data = stream_byte & vgm_csc_pkg::MASK_B;
        end
        else
        begin
            masked_data = stream_byte;
        end
    end

    always_comb
    begin
        addr_next   = cmd.hold_addr ? stream_byte : addr_reg;
        low_next    = cmd.hold_low ? stream_byte : low_reg;
        len_next    = len_reg;
        valid_next  = out_ready ? 1'b0 : valid_reg;
        first_next  = first_reg;
        second_next = second_reg;
        kind_next   = kind_reg;
        last_next   = last_reg;

        if (cmd.load_wait)
        begin
            len_next = {stream_byte, low_reg};
        end
        else if (cmd.load_wait735)
        begin
            len_next = {vgm_csc_pkg::WAIT735_HI, vgm_csc_pkg::WAIT735_LO};
        end

        case (cmd.out_op)
            vgm_csc_pkg::OUT_NONE:
            begin
            end
            vgm_csc_pkg::OUT_SHORT:
            begin
                valid_next  = 1'b1;
                first_next  = 8'd0;
                second_next = {4'd0, stream_byte[3:0]} + 8'd1;
                kind_next   = vgm_csc_pkg::KIND_SHORT;
                last_next   = 1'b1;
            end
            vgm_csc_pkg::OUT_WRITE:
            begin
                valid_next  = 1'b1;
                first_next  = addr_reg;
                second_next = masked_data;
                kind_next   = vgm_csc_pkg::KIND_WRITE;
                last_next   = 1'b1;
            end
            vgm_csc_pkg::OUT_PIECE:
            begin
                valid_next = 1'b1;
                kind_next  = vgm_csc_pkg::KIND_LONG;
                if (len_big)
                begin
                    first_next  = vgm_csc_pkg::PIECE_HI;
                    second_next = vgm_csc_pkg::PIECE_LO;
                    last_next   = 1'b0;
                    len_next    = len_reg - vgm_csc_pkg::PIECE_MAX;
                end
                else
                begin
                    first_next  = len_reg[15:8];
                    second_next = len_reg[7:0];
                    last_next   = 1'b1;
                end
            end
            vgm_csc_pkg::OUT_END:
            begin
                valid_next  = 1'b1;
                first_next  = 8'd0;
                second_next = 8'd0;
                kind_next   = vgm_csc_pkg::KIND_END;
                last_next   = 1'b1;
            end
            vgm_csc_pkg::OUT_BAD:
            begin
                valid_next  = 1'b1;
                first_next  = stream_byte;
                second_next = 8'd0;
                kind_next   = vgm_csc_pkg::KIND_BAD;
                last_next   = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg  <= 8'd0;
            low_reg   <= 8'd0;
            len_reg   <= 16'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            addr_reg  <= addr_next;
            low_reg   <= low_next;
            len_reg   <= len_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg  <= first_next;
        second_reg <= second_next;
        kind_reg   <= kind_next;
        last_reg   <= last_next;
    end

    assign out_valid   = valid_reg;
    assign first_byte  = first_reg;
    assign second_byte = second_reg;
    assign record_kind = kind_reg;
    assign last_of_run = last_reg;

    // a new record may only overwrite a slot that is empty or being taken
    `VGM_ASSERT_SAME(a_load_into_free, cmd.out_op != vgm_csc_pkg::OUT_NONE, out_free)
    // every full piece shortens the remaining wait by one piece
    `VGM_ASSERT_NEXT(a_piece_shrinks, cmd.out_op == vgm_csc_pkg::OUT_PIECE && len_big,
        len_reg == $past(len_reg) - vgm_csc_pkg::PIECE_MAX)

endmodule

### rtl/vgm_csc_ctrl.sv
// Controller: parse phase state machine that steers the datapath.
// Depends on vgm_csc_pkg and the assertion macro header.
`include "vgm_command_stream_converter_assert.svh"

module vgm_csc_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  vgm_csc_pkg::dp_status_t status,
    output vgm_csc_pkg::dp_cmd_t    cmd
);

    typedef enum logic [6:0] {
        ST_OPCODE = 7'b0000001,
        ST_ADDR   = 7'b0000010,
        ST_DATA   = 7'b0000100,
        ST_WLOW   = 7'b0001000,
        ST_WHIGH  = 7'b0010000,
        ST_LONG   = 7'b0100000,
        ST_HALT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   in_fire;

    always_comb
    begin
        case (state_reg)
            ST_HALT: in_ready = 1'b1;
            ST_LONG: in_ready = 1'b0;
            default: in_ready = status.out_free;
        endcase
    end

    assign in_fire = in_valid && in_ready;

    always_comb
    begin
        state_next       = state_reg;
        cmd.hold_addr    = 1'b0;
        cmd.hold_low     = 1'b0;
        cmd.load_wait    = 1'b0;
        cmd.load_wait735 = 1'b0;
        cmd.out_op       = vgm_csc_pkg::OUT_NONE;

        case (state_reg)
            ST_OPCODE:
            begin
                if (in_fire)
                begin
                    case (status.op_class)
                        vgm_csc_pkg::OPCL_SHORT:
                        begin
                            cmd.out_op = vgm_csc_pkg::OUT_SHORT;
                        end
                        vgm_csc_pkg::OPCL_WRITE:
                        begin
                            state_next = ST_ADDR;
                        end
                        vgm_csc_pkg::OPCL_WAIT:
                        begin
                            state_next = ST_WLOW;
                        end
                        vgm_csc_pkg::OPCL_WAIT735:
                        begin
                            cmd.load_wait735 = 1'b1;
                            state_next       = ST_LONG;
                        end
                        vgm_csc_pkg::OPCL_END:
                        begin
                            cmd.out_op = vgm_csc_pkg::OUT_END;
                            state_next = ST_HALT;
                        end
                        default:
                        begin
                            cmd.out_op = vgm_csc_pkg::OUT_BAD;
                            state_next = ST_HALT;
                        end
                    endcase
                end
            end
            ST_ADDR:
            begin
                if (in_fire)
                begin
                    cmd.hold_addr = 1'b1;
                    state_next    = ST_DATA;
                end
            end
            ST_DATA:
            begin
                if (in_fire)
                begin
                    cmd.out_op = vgm_csc_pkg::OUT_WRITE;
                    state_next = ST_OPCODE;
                end
            end
            ST_WLOW:
            begin
                if (in_fire)
                begin
                    cmd.hold_low = 1'b1;
                    state_next   = ST_WHIGH;
                end
            end
            ST_WHIGH:
            begin
                if (in_fire)
                begin
                    cmd.load_wait = 1'b1;
                    state_next    = ST_LONG;
                end
            end
            ST_LONG:
            begin
                // one piece per free output slot; the short remainder ends the wait
                if (status.out_free)
                begin
                    cmd.out_op = vgm_csc_pkg::OUT_PIECE;
                    if (!status.len_big)
                    begin
                        state_next = ST_OPCODE;
                    end
                end
            end
            ST_HALT:
            begin
            end
            default:
            begin
                state_next = ST_HALT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_OPCODE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `VGM_ASSERT_SAME(a_no_accept_in_long, state_reg == ST_LONG, !in_ready)
    `VGM_ASSERT_NEXT(a_high_starts_long, in_fire && state_reg == ST_WHIGH, state_reg == ST_LONG)
    `VGM_ASSERT_NEXT(a_halt_sticks, state_reg == ST_HALT, state_reg == ST_HALT)

endmodule
